FILE: hw/rtl/integer_square_root_defines.svh
// Assertion macros shared by the square root block.
`ifndef INTEGER_SQUARE_ROOT_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ISQRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("isqrt assertion failed");
`define ISQRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("isqrt assertion failed");
`else
`define ISQRT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ISQRT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/isqrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package isqrt_pkg;

	localparam int unsigned RAD_W  = 64;
	localparam int unsigned ROOT_W = 32;
	// The remainder never exceeds twice the partial root.
	localparam int unsigned REM_W  = ROOT_W + 2;
	localparam int unsigned CELLS  = RAD_W / 2;

	localparam logic CMD_FIX16 = 1'b0;
	localparam logic CMD_ROUND = 1'b1;

	typedef struct packed {
		logic              valid;
		logic              cmd;
		logic [RAD_W-1:0]  rad;
		logic [ROOT_W-1:0] root;
		logic [REM_W-1:0]  rem;
	} cell_t;

endpackage

`default_nettype wire

FILE: hw/rtl/integer_square_root.sv
// Integer square root, one root bit per cell in a chain of 32 cells followed
// by a rounding stage. A new transaction is taken in every clock cycle and busy
// stays low; each result appears on root with done high for one cycle, after the
// cells and the rounding register, in start order. The receiver cannot stall the block,
// so it must take every result in the cycle it is shown. With cmd low the low
// 32 bits of radicand give a 16.16 root; with cmd high the full 64 bits give
// the root rounded to the nearest integer, saturated to 32 bits.
`timescale 1ns / 1ps
`default_nettype none

`include "integer_square_root_defines.svh"

module integer_square_root
	import isqrt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic             cmd,
	input  wire logic [RAD_W-1:0] radicand,
	output logic                  done,
	output logic [ROOT_W-1:0]     root
);

	cell_t chain [CELLS+1];
	cell_t head;
	logic  rem_ok;

	assign busy = 1'b0;

	// Fixed-point mode roots the 32-bit value scaled by two to the thirtieth.
	always_comb begin
		head.valid = start && !busy;
		head.cmd   = cmd;
		head.rad   = (cmd == CMD_ROUND) ? radicand : {2'b00, radicand[31:0], 30'd0};
		head.root  = '0;
		head.rem   = '0;
	end

	assign chain[0] = head;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		isqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.prev    (chain[i]),
			.next_s1 (chain[i+1])
		);
	end

	isqrt_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.fin    (chain[CELLS]),
		.done   (done),
		.root   (root)
	);

	assign rem_ok = (chain[CELLS].rem <= {1'b0, chain[CELLS].root, 1'b0});

	`ISQRT_ASSERT_NXT(a_first_cell_loaded, clk, arst_n, start, chain[1].valid)
	`ISQRT_ASSERT_IMP(a_rem_bounded, clk, arst_n, chain[CELLS].valid, rem_ok)
	`ISQRT_ASSERT_IMP(a_never_busy, clk, arst_n, 1'b1, !busy)

endmodule

`default_nettype wire

FILE: hw/rtl/isqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module isqrt_cell
	import isqrt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cell_t prev,
	output cell_t      next_s1
);

	logic [REM_W+1:0] rem_w;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	logic             ge;

	// Bring down the next two radicand bits and try the digit one.
	assign rem_w = {prev.rem, prev.rad[RAD_W-1 -: 2]};
	assign trial = {2'b00, prev.root, 2'b01};
	assign diff  = rem_w - trial;
	assign ge    = (rem_w >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_s1 <= '0;
		end else begin
			next_s1.valid <= prev.valid;
			next_s1.cmd   <= prev.cmd;
			next_s1.rad   <= {prev.rad[RAD_W-3:0], 2'b00};
			next_s1.root  <= {prev.root[ROOT_W-2:0], ge};
			next_s1.rem   <= ge ? diff[REM_W-1:0] : rem_w[REM_W-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/isqrt_round.sv
`timescale 1ns / 1ps
`default_nettype none

`include "integer_square_root_defines.svh"

module isqrt_round
	import isqrt_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cell_t        fin,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [ROOT_W:0]   root_inc;
	logic              up;
	logic [ROOT_W-1:0] rounded;
	logic [ROOT_W-1:0] result;

	// Round half up: add one when the remainder exceeds the floor root.
	assign up       = (fin.rem > {2'b00, fin.root});
	assign root_inc = {1'b0, fin.root} + {{ROOT_W{1'b0}}, up};
	assign rounded  = root_inc[ROOT_W] ? {ROOT_W{1'b1}} : root_inc[ROOT_W-1:0];
	assign result   = (fin.cmd == CMD_ROUND) ? rounded : {fin.root[ROOT_W-2:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		root <= result;
	end

	`ISQRT_ASSERT_NXT(a_done_follows, clk, arst_n, fin.valid, done)
	`ISQRT_ASSERT_NXT(a_no_spurious_done, clk, arst_n, !fin.valid, !done)
	`ISQRT_ASSERT_NXT(a_fix16_even, clk, arst_n, fin.valid && fin.cmd == CMD_FIX16, !root[0])

endmodule

`default_nettype wire

FILE: tb/integer_square_root_checker.sv
`timescale 1ns / 1ps

// Watches both sides of the square root block, predicts every root and
// compares the results in order.
module integer_square_root_checker
	import isqrt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire logic              cmd,
	input  wire logic [RAD_W-1:0]  radicand,
	input  wire logic              done,
	input  wire logic [ROOT_W-1:0] root,
	output int                     mismatches,
	output int                     roots_pending
);

	logic [ROOT_W-1:0] roots_due[$];

	// Restoring digit-by-digit root: floor(sqrt(n)) with the remainder n - r^2.
	// The working remainder is kept wide so nothing is lost near the top of the range.
	function automatic logic [ROOT_W-1:0] floor_root(input logic [RAD_W-1:0] n,
			output logic [39:0] rest);
		logic [39:0] acc;
		logic [39:0] trial;
		logic [ROOT_W-1:0] r;
		acc = '0;
		r = '0;
		for (int i = RAD_W / 2 - 1; i >= 0; i--) begin
			acc = {acc[37:0], n[2*i+1 -: 2]};
			trial = {6'd0, r, 2'b01};
			if (acc >= trial) begin
				acc = acc - trial;
				r = {r[ROOT_W-2:0], 1'b1};
			end else begin
				r = {r[ROOT_W-2:0], 1'b0};
			end
		end
		rest = acc;
		return r;
	endfunction

	function automatic logic [ROOT_W-1:0] predict_root(input logic mode,
			input logic [RAD_W-1:0] value);
		logic [39:0] rest;
		logic [ROOT_W-1:0] r;
		logic [ROOT_W:0] rounded;
		if (mode == CMD_FIX16) begin
			// Only the low word counts; the root of v * 2^30 is doubled into 16.16.
			r = floor_root({2'b00, value[31:0], 30'd0}, rest);
			return {r[ROOT_W-2:0], 1'b0};
		end
		r = floor_root(value, rest);
		rounded = {1'b0, r} + {{ROOT_W{1'b0}}, (rest > {8'd0, r})};
		return rounded[ROOT_W] ? {ROOT_W{1'b1}} : rounded[ROOT_W-1:0];
	endfunction

	initial begin
		mismatches = 0;
		roots_pending = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (roots_due.size() == 0) begin
					$error("root: result %h arrived with no transaction outstanding", root);
					mismatches = mismatches + 1;
				end else begin
					if (root !== roots_due[0]) begin
						$error("root mismatch: expected %h, actual %h", roots_due[0], root);
						mismatches = mismatches + 1;
					end
					void'(roots_due.pop_front());
				end
			end
			if (start && !busy)
				roots_due.push_back(predict_root(cmd, radicand));
			roots_pending = roots_due.size();
		end
	end

endmodule

FILE: tb/integer_square_root_test.sv
`timescale 1ns / 1ps

module integer_square_root_test;
	import isqrt_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              cmd = CMD_FIX16;
	logic [RAD_W-1:0]  radicand = '0;
	logic              busy;
	logic              done;
	logic [ROOT_W-1:0] root;
	int                failures;
	int                pending;
	int                quiet_cycles = 0;

	always #6 clk = ~clk;

	integer_square_root i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.radicand (radicand),
		.done     (done),
		.root     (root)
	);

	integer_square_root_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.radicand      (radicand),
		.done          (done),
		.root          (root),
		.mismatches    (failures),
		.roots_pending (pending)
	);

	// Ends the run if neither side moves a transaction for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Called just after a falling edge; returns just after the falling edge that
	// follows acceptance, with start left high.
	task automatic issue(input logic mode, input logic [RAD_W-1:0] value, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cmd <= mode;
		radicand <= value;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic random_phase(input int count, input int idle_pct);
		logic [RAD_W-1:0] value;
		logic [31:0] side;
		for (int n = 0; n < count; n++) begin
			side = $urandom;
			case ($urandom_range(3))
				0: value = {$urandom, $urandom};
				1: value = {$urandom, $urandom} >> $urandom_range(63);
				// Values around side * side + side straddle the rounding edge.
				2: value = side * side + {32'd0, side} + $urandom_range(2) - 1;
				default: value = side * side + $urandom_range(2) - 1;
			endcase
			issue($urandom_range(1) ? CMD_ROUND : CMD_FIX16, value, idle_pct);
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Word-mode extremes; the upper half of the radicand must be ignored.
		issue(CMD_FIX16, 64'h0, 0);
		issue(CMD_FIX16, 64'h1, 0);
		issue(CMD_FIX16, 64'h0000_0000_8000_0000, 0);
		issue(CMD_FIX16, 64'h0000_0000_FFFF_FFFF, 0);
		issue(CMD_FIX16, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		issue(CMD_FIX16, 64'hDEAD_BEEF_0000_0004, 0);
		// Rounded mode: small values, rounding either way, exact squares.
		issue(CMD_ROUND, 64'h0, 0);
		issue(CMD_ROUND, 64'h1, 0);
		issue(CMD_ROUND, 64'h2, 0);
		issue(CMD_ROUND, 64'h3, 0);
		issue(CMD_ROUND, 64'd12, 0);
		issue(CMD_ROUND, 64'd13, 0);
		issue(CMD_ROUND, 64'h4000_0000_0000_0000, 0);
		issue(CMD_ROUND, 64'h8000_0000_0000_0000, 0);
		// Top of the range: exact, just below rounding up, and saturating.
		issue(CMD_ROUND, 64'hFFFF_FFFE_0000_0001, 0);
		issue(CMD_ROUND, 64'hFFFF_FFFF_0000_0000, 0);
		issue(CMD_ROUND, 64'hFFFF_FFFF_0000_0001, 0);
		issue(CMD_ROUND, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		drain();

		random_phase(280, 27);
		drain();
		random_phase(280, 61);
		random_phase(290, 0);
		drain();

		repeat (40) @(negedge clk);
		if (failures == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/isqrt_pkg.sv
hw/rtl/isqrt_cell.sv
hw/rtl/isqrt_round.sv
hw/rtl/integer_square_root.sv
tb/integer_square_root_checker.sv
tb/integer_square_root_test.sv
